// ===== rtl/ubsd_pkg.sv =====
package ubsd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CP_W   = 31;
	localparam int unsigned CNT_W  = 3;

	localparam logic [CP_W-1:0] REPLACEMENT_CP = 31'h0000_FFFD;

	// Decoder state carried from one item to the next
	typedef struct packed {
		logic [CNT_W-1:0] bytes_left;
		logic [CP_W-1:0]  value_so_far;
		logic             sequence_bad;
	} dec_state_t;

	// What one item produces
	typedef struct packed {
		logic            emit;
		logic [CP_W-1:0] code_point;
		logic            replaced;
	} dec_result_t;

	localparam dec_state_t STATE_CLEAR = '{bytes_left: '0, value_so_far: '0, sequence_bad: 1'b0};

endpackage

// ===== rtl/ubsd_step.sv =====
module ubsd_step (
	input  ubsd_pkg::dec_state_t         cur,
	input  logic [ubsd_pkg::BYTE_W-1:0]  data_byte,
	input  logic                         end_of_stream,
	output ubsd_pkg::dec_state_t         nxt,
	output ubsd_pkg::dec_result_t        res
);

	logic [ubsd_pkg::CNT_W-1:0]  lead_len;
	logic [4:0]                  lead_bits;
	logic                        is_cont;
	logic [ubsd_pkg::CNT_W-1:0]  left_dec;
	logic [ubsd_pkg::CP_W-1:0]   shifted;

	// Sequence length announced by a lead byte; 0 when it cannot lead
	always_comb begin
		case (data_byte) inside
			8'b0???????: lead_len = 3'd1;
			8'b10??????: lead_len = 3'd0;
			8'b110?????: lead_len = 3'd2;
			8'b1110????: lead_len = 3'd3;
			8'b11110???: lead_len = 3'd4;
			8'b111110??: lead_len = 3'd5;
			8'b1111110?: lead_len = 3'd6;
			default:     lead_len = 3'd0;
		endcase
	end

	// Payload bits of the lead: mask 0x7F >> len, only 5 bits can survive
	always_comb begin
		lead_bits = data_byte[4:0] & (5'h1F >> (lead_len - 3'd2));
	end

	assign is_cont  = (data_byte[7:6] == 2'b10);
	assign left_dec = cur.bytes_left - 3'd1;
	assign shifted  = {cur.value_so_far[ubsd_pkg::CP_W-7:0], data_byte[5:0]};

	always_comb begin
		nxt = cur;
		res = '{emit: 1'b0, code_point: ubsd_pkg::REPLACEMENT_CP, replaced: 1'b1};
		if (end_of_stream) begin
			nxt      = ubsd_pkg::STATE_CLEAR;
			res.emit = (cur.bytes_left != '0);
		end else if (cur.bytes_left == '0) begin
			if (lead_len == 3'd1) begin
				res.emit       = 1'b1;
				res.code_point = {{(ubsd_pkg::CP_W-ubsd_pkg::BYTE_W){1'b0}}, data_byte};
				res.replaced   = 1'b0;
			end else if (lead_len == 3'd0) begin
				res.emit = 1'b1;
			end else begin
				nxt.value_so_far = {{(ubsd_pkg::CP_W-5){1'b0}}, lead_bits};
				nxt.bytes_left   = lead_len - 3'd1;
				nxt.sequence_bad = 1'b0;
			end
		end else begin
			if (is_cont) begin
				nxt.value_so_far = shifted;
			end else begin
				nxt.sequence_bad = 1'b1;
			end
			nxt.bytes_left = left_dec;
			if (left_dec == '0) begin
				res.emit     = 1'b1;
				res.replaced = nxt.sequence_bad;
				if (!nxt.sequence_bad) begin
					res.code_point = nxt.value_so_far;
				end
				nxt = ubsd_pkg::STATE_CLEAR;
			end
		end
	end

endmodule

// ===== rtl/utf8_byte_stream_decoder_top.sv =====
// UTF-8 byte stream decoder, original forms with up to six bytes per sequence.
// Input channel: in_valid / in_stall carry one item per handshake, either a
// raw byte (data_byte) or an end marker (end_of_stream = 1, byte ignored).
// Output channel: out_valid / out_stall carry one decoded item: a 31-bit
// code_point and the replaced flag, set when U+FFFD stands for bad input.
// An item is taken at a rising edge with valid high and stall low.
// Path: an item taken in waits in the input register, is decoded there,
// and its result lands in the output register; out_valid shows it
// from then on. Items that complete nothing (leads, inner continuation
// bytes, end marker with no sequence open) give no output item.
// Throughput: one item per clock unless out_stall holds it, set by the single
// decode step between the input and output registers, which also updates the state.
// Reset (arst_n low) empties both registers and clears the open sequence.
// When out_stall holds a result, the input register still drains if its
// item gives no output; otherwise in_stall rises and the item waits.
module utf8_byte_stream_decoder_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [ubsd_pkg::BYTE_W-1:0]    data_byte,
	input  logic                           end_of_stream,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ubsd_pkg::CP_W-1:0]      code_point,
	output logic                           replaced
);

	// input register
	logic                          valid_s1;
	logic [ubsd_pkg::BYTE_W-1:0]   byte_s1;
	logic                          eos_s1;

	// decode state and output register
	ubsd_pkg::dec_state_t          state_q;
	ubsd_pkg::dec_state_t          state_nxt;
	ubsd_pkg::dec_result_t         res;
	logic                          out_valid_q;
	logic [ubsd_pkg::CP_W-1:0]     cp_q;
	logic                          rep_q;

	logic out_free;
	logic s1_go;
	logic in_take;

	ubsd_step u_step (
		.cur           (state_q),
		.data_byte     (byte_s1),
		.end_of_stream (eos_s1),
		.nxt           (state_nxt),
		.res           (res)
	);

	// Output slot frees up when empty or being taken this cycle.
	assign out_free = !out_valid_q || !out_stall;
	// An item in s1 moves on unless its result would hit a full output slot.
	assign s1_go    = valid_s1 && (out_free || !res.emit);
	assign in_stall = valid_s1 && !s1_go;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= data_byte;
			eos_s1  <= end_of_stream;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ubsd_pkg::STATE_CLEAR;
		end else if (s1_go) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_go && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_go && res.emit) begin
			cp_q  <= res.code_point;
			rep_q <= res.replaced;
		end
	end

	assign out_valid  = out_valid_q;
	assign code_point = cp_q;
	assign replaced   = rep_q;

	// a substituted item always carries U+FFFD
	a_rep_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rep_q |-> cp_q == ubsd_pkg::REPLACEMENT_CP)
		else $error("replaced item without U+FFFD");

	// at most five continuation bytes can be pending
	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.bytes_left <= 3'd5)
		else $error("bytes_left out of range");

	// an end marker always closes the open sequence
	a_eos_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && eos_s1 |=> state_q.bytes_left == '0)
		else $error("end marker left a sequence open");

	// a new output item only comes from an item leaving the input register
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_go && res.emit))
		else $error("output item without a source");

	// an item that emits is never dropped while the output slot is full
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res.emit && !out_free |=> valid_s1 && $stable(byte_s1))
		else $error("emitting item lost under stall");

endmodule

// ===== verif/utf8_byte_stream_decoder_top_test.sv =====
`timescale 1ns / 1ps

module utf8_byte_stream_decoder_top_test;

	// cycles with no handshake on either side before the run is declared hung
	localparam int unsigned HANG_LIMIT = 2000;

	// one byte (or end marker) headed into the decoder
	typedef struct {
		logic [ubsd_pkg::BYTE_W-1:0] data;
		logic                        eos;
	} stream_item_t;

	// one decoded item as it should leave the decoder
	typedef struct {
		logic [ubsd_pkg::CP_W-1:0] code_point;
		logic                      replaced;
	} cp_item_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [ubsd_pkg::BYTE_W-1:0] data_byte = '0;
	logic                        end_of_stream = 1'b0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [ubsd_pkg::CP_W-1:0]   code_point;
	logic                        replaced;

	utf8_byte_stream_decoder_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.code_point    (code_point),
		.replaced      (replaced)
	);

	always #4 clk = ~clk;

	// bytes waiting to be sent, and decoded items still owed by the block
	stream_item_t byte_queue[$];
	cp_item_t     expected_cps[$];

	int unsigned items_queued = 0;
	int unsigned items_accepted = 0;
	int unsigned fail_count = 0;
	int unsigned quiet_cycles = 0;
	logic        calm = 1'b0;	// set for the last stretch: no gaps, no stalls

	// driver-side burst counters
	int unsigned send_gap = 0;
	int unsigned stall_left = 0;
	stream_item_t upcoming;

	// decoder shadow: sequence still open in the stream
	logic [ubsd_pkg::CNT_W-1:0] open_left = '0;
	logic [ubsd_pkg::CP_W-1:0]  open_value = '0;
	logic                       open_bad = 1'b0;

	// Advances the shadow decoder by one item. Returns 1 when the item
	// completes something, with the decoded item in res.
	function automatic logic decode_predict(input logic [ubsd_pkg::BYTE_W-1:0] b,
			input logic eos, output cp_item_t res);
		logic [ubsd_pkg::CNT_W-1:0] len;
		logic                       emit;
		res.code_point = ubsd_pkg::REPLACEMENT_CP;
		res.replaced = 1'b1;
		// end marker: flags a cut-off sequence, otherwise silent
		if (eos) begin
			emit = (open_left != 0);
			open_left = '0;
			open_value = '0;
			open_bad = 1'b0;
			return emit;
		end
		if (open_left == 0) begin
			// lead position: the top bits announce the length
			casez (b)
				8'b0???????: len = 3'd1;
				8'b110?????: len = 3'd2;
				8'b1110????: len = 3'd3;
				8'b11110???: len = 3'd4;
				8'b111110??: len = 3'd5;
				8'b1111110?: len = 3'd6;
				default:     len = 3'd0;	// stray continuation, 0xFE, 0xFF
			endcase
			if (len == 3'd1) begin
				res.code_point = '0;
				res.code_point[ubsd_pkg::BYTE_W-1:0] = b;
				res.replaced = 1'b0;
				return 1'b1;
			end
			if (len == 3'd0)
				return 1'b1;
			open_value = '0;
			open_value[ubsd_pkg::BYTE_W-1:0] = b & (8'h7F >> len);
			open_left = len - 1'b1;
			open_bad = 1'b0;
			return 1'b0;
		end
		// inside a sequence: a non-continuation byte still uses up a slot
		if (b[7:6] == 2'b10)
			open_value = {open_value[ubsd_pkg::CP_W-7:0], b[5:0]};
		else
			open_bad = 1'b1;
		open_left = open_left - 1'b1;
		if (open_left != 0)
			return 1'b0;
		if (!open_bad) begin
			res.code_point = open_value;
			res.replaced = 1'b0;
		end
		open_value = '0;
		open_bad = 1'b0;
		return 1'b1;
	endfunction

	task automatic queue_item(input logic [ubsd_pkg::BYTE_W-1:0] data, input logic eos);
		stream_item_t it;
		it.data = data;
		it.eos = eos;
		byte_queue.push_back(it);
		items_queued++;
	endtask

	// Queues a sequence of len bytes with random payload.
	// flaw 0: clean; 1: one continuation swapped for a non-continuation byte;
	// 2: cut short by an end marker.
	task automatic queue_sequence(input int unsigned len, input int unsigned flaw);
		logic [ubsd_pkg::BYTE_W-1:0] prefix;
		logic [ubsd_pkg::BYTE_W-1:0] b;
		int unsigned                 spoil;
		int unsigned                 sent;
		prefix = (len == 1) ? 8'h00 : (8'hFF << (8 - len));
		b = 8'($urandom);
		queue_item(prefix | (b & (8'h7F >> len)), 1'b0);
		spoil = (flaw == 1) ? $urandom_range(len - 1, 1) : 0;
		sent = (flaw == 2) ? $urandom_range(len - 2, 0) : len - 1;
		for (int unsigned i = 1; i <= sent; i++) begin
			b = 8'($urandom);
			if (i == spoil) begin
				if (b[7:6] == 2'b10)
					b[6] = 1'b1;
			end else begin
				b[7:6] = 2'b10;
			end
			queue_item(b, 1'b0);
		end
		if (flaw == 2)
			queue_item(8'($urandom), 1'b1);
	endtask

	// Mostly well-formed text, with broken sequences and raw noise mixed in.
	task automatic queue_random(input int unsigned count);
		int unsigned target;
		int unsigned pick;
		target = items_queued + count;
		while (items_queued < target) begin
			pick = $urandom_range(99);
			if (pick < 70)
				queue_sequence($urandom_range(6, 1), 0);
			else if (pick < 80)
				queue_sequence($urandom_range(6, 2), 1);
			else if (pick < 88)
				queue_sequence($urandom_range(6, 2), 2);
			else if (pick < 95)
				queue_item(8'($urandom), 1'b0);
			else
				queue_item(8'($urandom), 1'b1);
		end
	endtask

	// Holds the stimulus until every queued item is in and every result is out.
	task automatic wait_for_drain();
		while (byte_queue.size() != 0 || items_accepted != items_queued
				|| expected_cps.size() != 0)
			@(posedge clk);
	endtask

	// Driver: feeds items from byte_queue, inserts sender gaps and output stalls.
	// A presented item is held until the block takes it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= '0;
			end_of_stream <= 1'b0;
			out_stall <= 1'b0;
			send_gap <= 0;
			stall_left <= 0;
		end else begin
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (byte_queue.size() != 0) begin
					upcoming = byte_queue.pop_front();
					data_byte <= upcoming.data;
					end_of_stream <= upcoming.eos;
					in_valid <= 1'b1;
					// now and then leave an idle gap after this item
					if (!calm && $urandom_range(7) == 0)
						send_gap <= $urandom_range(6, 1);
				end else begin
					in_valid <= 1'b0;
				end
			end
			// random receiver stall bursts
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(5) == 0) begin
				stall_left <= $urandom_range(5, 0);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Monitor: checks each decoded item against the oldest expectation, then
	// runs the shadow decoder on each item taken in. Also the hang watchdog.
	cp_item_t want;
	cp_item_t got;
	logic     took_any;

	always @(posedge clk) begin
		if (arst_n) begin
			took_any = 1'b0;
			if (out_valid && !out_stall) begin
				took_any = 1'b1;
				if (expected_cps.size() == 0) begin
					$error("unexpected item: code_point %h replaced %b", code_point, replaced);
					fail_count++;
				end else begin
					want = expected_cps.pop_front();
					if (code_point !== want.code_point) begin
						$error("code_point: expected %h, actual %h", want.code_point, code_point);
						fail_count++;
					end
					if (replaced !== want.replaced) begin
						$error("replaced: expected %b, actual %b", want.replaced, replaced);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				took_any = 1'b1;
				items_accepted++;
				if (decode_predict(data_byte, end_of_stream, got))
					expected_cps.push_back(got);
			end
			quiet_cycles = took_any ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: ASCII extremes
		queue_item(8'h00, 1'b0);
		queue_item(8'h7F, 1'b0);
		// stray continuation and the two bytes that never lead
		queue_item(8'h80, 1'b0);
		queue_item(8'hFE, 1'b0);
		queue_item(8'hFF, 1'b0);
		// largest two-byte value
		queue_item(8'hDF, 1'b0);
		queue_item(8'hBF, 1'b0);
		// a genuine U+FFFD in the stream, not flagged
		queue_item(8'hEF, 1'b0);
		queue_item(8'hBF, 1'b0);
		queue_item(8'hBD, 1'b0);
		// six-byte form with every payload bit set: 0x7FFFFFFF
		queue_item(8'hFD, 1'b0);
		repeat (5) queue_item(8'hBF, 1'b0);
		// five-byte form, all payload zero (overlong, accepted)
		queue_item(8'hF8, 1'b0);
		repeat (4) queue_item(8'h80, 1'b0);
		// bad byte mid-sequence: sequence runs to its length, then U+FFFD
		queue_item(8'hE0, 1'b0);
		queue_item(8'h41, 1'b0);
		queue_item(8'h80, 1'b0);
		// end marker cutting a four-byte sequence short
		queue_item(8'hF0, 1'b0);
		queue_item(8'h90, 1'b0);
		queue_item(8'h00, 1'b1);
		// end marker with nothing open: no item out
		queue_item(8'hFF, 1'b1);
		wait_for_drain();

		// random text; the sender pauses for a full drain between parts
		queue_random(280);
		wait_for_drain();
		queue_random(270);
		wait_for_drain();

		// last stretch with no gaps and no stalls
		calm = 1'b1;
		queue_random(100);
		wait_for_drain();

		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/ubsd_pkg.sv
rtl/ubsd_step.sv
rtl/utf8_byte_stream_decoder_top.sv
verif/utf8_byte_stream_decoder_top_test.sv
